>>> sv/assert_macros.svh
// assertion macros shared by the probe selector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define ILPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define ILPS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`else

`define ILPS_ASSERT(lbl, prop, msg)
`define ILPS_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

>>> sv/ilps_pkg.sv
// types, constants and codes for the idle link probe selector
package ilps_pkg;

    localparam int MAX_LINKS_DEF = 64;
    localparam int SLOT_W        = 6;
    localparam int TIME_W        = 48;
    localparam int FRAME_W       = 64;

    // request codes
    localparam logic [1:0] REQ_REPORT = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [SLOT_W-1:0]  link_index;
        logic [TIME_W-1:0]  now_ms;
        logic [FRAME_W-1:0] tx_frames;
        logic               link_symmetric;
        logic               l2_data_present;
        logic               probe_flag_known;
        logic               probe_flag_value;
        logic               iface_is_dlep;
        logic               iface_is_wireless;
        logic               has_address;
    } req_t;

    typedef struct packed {
        logic               candidate_found;
        logic               send_probe;
        logic [SLOT_W-1:0]  chosen_link;
        logic [TIME_W-1:0]  idle_time;
    } result_t;

    // one per-link memory word
    typedef struct packed {
        logic               target_ready;
        logic [TIME_W-1:0]  check_time;
        logic [FRAME_W-1:0] prev_tx;
    } link_entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic clr_en;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } dp_status_t;

endpackage

>>> sv/ilps_ctrl.sv
// controller state machine: memory clearing pass, idle, execute
`include "assert_macros.svh"

module ilps_ctrl
    import ilps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        cmd.clr_en = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `ILPS_ASSERT_NEXT(a_accept_execs, cmd.accept, cmd.exec, "accepted word not executed")
    `ILPS_ASSERT_NEXT(a_exec_single, cmd.exec, !cmd.exec && !busy, "execute held past one cycle")
    `ILPS_ASSERT(a_no_accept_clear, !(cmd.clr_en && cmd.accept), "word accepted during clear")

endmodule

>>> sv/ilps_datapath.sv
// datapath: per-link memory, candidate registers, config and result registers
`include "assert_macros.svh"

module ilps_datapath
    import ilps_pkg::*;
#(
    parameter int MAX_LINKS = MAX_LINKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  req_t       req,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    output logic       result_valid,
    output result_t    result
);

    localparam int IDX_W = $clog2(MAX_LINKS);

    link_entry_t mem [MAX_LINKS];

    link_entry_t        rd_word_reg;
    req_t               req_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic               in_range_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic               dlep_en_reg;

    logic               best_valid_reg;
    logic [SLOT_W-1:0]  best_slot_reg;
    logic [TIME_W-1:0]  best_idle_reg;
    logic               best_addr_reg;

    logic               result_valid_reg;
    result_t            result_reg;

    logic [31:0]        link_wide;
    logic [31:0]        best_wide;
    logic [IDX_W-1:0]   rd_addr;
    logic               in_range;

    logic               eligible;
    logic               rep_ok;
    logic               changed;
    logic [TIME_W-1:0]  idle_calc;
    logic               better;
    logic               target_new;
    logic               wr_en;
    link_entry_t        wr_word;
    logic               best_set;
    logic               best_clr;

    // address selection at accept
    always_comb
    begin
        link_wide = {{(32 - SLOT_W){1'b0}}, req.link_index};
        best_wide = {{(32 - SLOT_W){1'b0}}, best_slot_reg};
        in_range  = (link_wide < 32'(MAX_LINKS));
        rd_addr   = (req.req_type == REQ_END) ? best_wide[IDX_W-1:0] : link_wide[IDX_W-1:0];
    end

    // request word capture and memory read
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg      <= req;
            addr_reg     <= rd_addr;
            in_range_reg <= in_range;
            rd_word_reg  <= mem[rd_addr];
        end
    end

    // execute step: eligibility, idle time and write word
    always_comb
    begin
        if (req_reg.probe_flag_known)
        begin
            eligible = req_reg.probe_flag_value;
        end
        else if (req_reg.iface_is_dlep)
        begin
            eligible = dlep_en_reg;
        end
        else
        begin
            eligible = req_reg.iface_is_wireless;
        end
        rep_ok     = in_range_reg && eligible && req_reg.link_symmetric
                     && req_reg.l2_data_present;
        changed    = (rd_word_reg.prev_tx != req_reg.tx_frames);
        idle_calc  = req_reg.now_ms - rd_word_reg.check_time;
        better     = (idle_calc > best_idle_reg);
        target_new = rd_word_reg.target_ready | best_addr_reg;

        wr_en    = 1'b0;
        wr_word  = rd_word_reg;
        best_set = 1'b0;
        best_clr = 1'b0;
        if (cmd.exec)
        begin
            unique case (req_reg.req_type)
                REQ_REPORT:
                begin
                    wr_en           = rep_ok;
                    wr_word.prev_tx = req_reg.tx_frames;
                    if (changed)
                    begin
                        wr_word.check_time = req_reg.now_ms;
                    end
                    best_set = rep_ok && !changed && better;
                end
                REQ_END:
                begin
                    wr_en                = best_valid_reg;
                    wr_word.check_time   = req_reg.now_ms;
                    wr_word.target_ready = target_new;
                    best_clr             = 1'b1;
                end
                REQ_REMOVE:
                begin
                    wr_en    = in_range_reg;
                    wr_word  = '0;
                    best_clr = in_range_reg && best_valid_reg
                               && (best_slot_reg == req_reg.link_index);
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // per-link memory write, clearing pass after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr_reg] <= wr_word;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign status.clr_last = (clr_cnt_reg == IDX_W'(MAX_LINKS - 1));

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlep_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            dlep_en_reg <= cfg_data;
        end
    end

    // candidate registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_slot_reg  <= '0;
            best_idle_reg  <= '0;
            best_addr_reg  <= 1'b0;
        end
        else if (best_clr)
        begin
            best_valid_reg <= 1'b0;
            best_slot_reg  <= '0;
            best_idle_reg  <= '0;
            best_addr_reg  <= 1'b0;
        end
        else if (best_set)
        begin
            best_valid_reg <= 1'b1;
            best_slot_reg  <= req_reg.link_index;
            best_idle_reg  <= idle_calc;
            best_addr_reg  <= req_reg.has_address;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.exec && (req_reg.req_type == REQ_END);
        end
    end

    // result word, zero without a candidate
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (req_reg.req_type == REQ_END))
        begin
            result_reg.candidate_found <= best_valid_reg;
            result_reg.send_probe      <= best_valid_reg && target_new;
            result_reg.chosen_link     <= best_valid_reg ? best_slot_reg : '0;
            result_reg.idle_time       <= best_valid_reg ? best_idle_reg : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ILPS_ASSERT(a_result_after_exec, !result_valid || $past(cmd.exec),
        "result word without execute step")
    `ILPS_ASSERT(a_no_candidate_zero,
        !result_valid || result.candidate_found
        || (result.chosen_link == '0 && result.idle_time == '0 && !result.send_probe),
        "empty result word carries data")
    `ILPS_ASSERT(a_best_idle_zero, best_valid_reg || best_idle_reg == '0,
        "idle time held without candidate")

endmodule

>>> sv/idle_link_probe_selector_top.sv
// Idle link probe selector: each request word is accepted, then goes through
// a memory read-modify-write step before the next is taken; busy is high
// during the execute step. An end-of-scan word gives its result strobe, for
// one cycle, from the result registers after its execute step; the receiver
// cannot stall it. After reset the per-link memory is zeroed one entry a cycle,
// all MAX_LINKS entries with busy high; configuration writes are taken throughout.
module idle_link_probe_selector_top
    import ilps_pkg::*;
#(
    parameter int MAX_LINKS = MAX_LINKS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    req,
    output logic    result_valid,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // configuration register always takes a write
    assign cfg_ready = 1'b1;

    ilps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    ilps_datapath #(
        .MAX_LINKS (MAX_LINKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
